[hw/rtl/ole_pkg.sv]
package ole_pkg;

  parameter int unsigned DefaultDepth = 16;
  parameter int unsigned ValueWidth   = 32;
  parameter int unsigned PosWidth     = 5;
  parameter int unsigned StatusWidth  = 3;
  parameter int unsigned OpWidth      = 2;

  typedef enum logic [OpWidth-1:0] {
    OpInsert = 2'd0,
    OpRemove = 2'd1,
    OpDump   = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    StatusOk       = 3'd0,
    StatusRange    = 3'd1,
    StatusNotFound = 3'd2,
    StatusFull     = 3'd3,
    StatusEntry    = 3'd4,
    StatusEmpty    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    StIdle,
    StInsStep,
    StInsMove,
    StRemRead,
    StRemCmp,
    StRemShift,
    StRemMove,
    StDumpRead,
    StDumpOut,
    StResp
  } state_e;

  typedef struct packed {
    status_e               status;
    logic [ValueWidth-1:0] entry;
    logic                  last;
  } res_t;

endpackage

[hw/rtl/ole_res_fifo.sv]
module ole_res_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_valid_i,
  output logic                              push_ready_o,
  input  ole_pkg::res_t                     push_data_i,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ole_pkg::ValueWidth-1:0]    m_axis_tdata,  // entry
  output logic [ole_pkg::StatusWidth-1:0]   m_axis_tuser,  // status
  output logic                              m_axis_tlast   // last
);

  ole_pkg::res_t buf_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;
  ole_pkg::res_t head;

  assign push_ready_o  = (cnt_q != 2'd2);
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign push          = push_valid_i & push_ready_o;
  assign pop           = m_axis_tvalid & m_axis_tready;

  assign head          = buf_q[rd_ptr_q];
  assign m_axis_tdata  = head.entry;
  assign m_axis_tuser  = head.status;
  assign m_axis_tlast  = head.last;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/ordered_list_engine_core.sv]
// Ordered list of up to Depth signed 32-bit words held in a one-port-read,
// one-port-write synchronous RAM. Each transaction on the slave side carries
// an op in tuser: insert at a position, remove the first equal entry, dump,
// or op 3, which is dropped. Insert and remove answer with one result; dump
// streams every entry front to back with tlast on the final one, or a single
// "empty" result. Results go through a two-entry output buffer. One item is
// worked on at a time and RAM reads are registered, so every entry moved,
// compared or dumped needs a read state and a write, compare or output state.
// An insert shifts the entries from its position up by one; a remove scans
// for a match and shifts the later ones down. The RAM content is undefined
// after reset; only entries below the current length are read.
module ordered_list_engine_core #(
  parameter int unsigned Depth = ole_pkg::DefaultDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [39:0]                     s_axis_tdata,  // value[31:0], position[36:32], zero pad
  input  logic [ole_pkg::OpWidth-1:0]     s_axis_tuser,  // op
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ole_pkg::ValueWidth-1:0]  m_axis_tdata,  // entry
  output logic [ole_pkg::StatusWidth-1:0] m_axis_tuser,  // status
  output logic                            m_axis_tlast   // last
);

  localparam int unsigned LW = $clog2(Depth + 1);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = (LW > ole_pkg::PosWidth) ? LW : ole_pkg::PosWidth;
  localparam int unsigned VW = ole_pkg::ValueWidth;

  ole_pkg::state_e state_q, state_d;
  logic [LW-1:0]   len_q, len_d;
  logic [LW-1:0]   idx_q, idx_d;
  logic [LW-1:0]   pos_q, pos_d;
  logic [VW-1:0]   val_q, val_d;
  ole_pkg::status_e status_q, status_d;
  logic [VW-1:0]   rdata_q;
  logic [VW-1:0]   mem [Depth];

  logic                          accept;
  ole_pkg::op_e                  in_op;
  logic [VW-1:0]                 in_value;
  logic [ole_pkg::PosWidth-1:0]  in_pos;
  logic [LW-1:0]                 idx_m1, idx_p1;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic          res_valid, res_ready;
  ole_pkg::res_t res;

  assign in_op    = ole_pkg::op_e'(s_axis_tuser);
  assign in_value = s_axis_tdata[VW-1:0];
  assign in_pos   = s_axis_tdata[VW+ole_pkg::PosWidth-1:VW];

  assign s_axis_tready = (state_q == ole_pkg::StIdle);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign idx_m1        = idx_q - LW'(1);
  assign idx_p1        = idx_q + LW'(1);

  // next state and datapath registers
  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    val_d    = val_q;
    status_d = status_q;
    case (state_q)
      ole_pkg::StIdle: begin
        if (accept) begin
          val_d = in_value;
          case (in_op)
            ole_pkg::OpInsert: begin
              if (CW'(in_pos) > CW'(len_q)) begin
                status_d = ole_pkg::StatusRange;
                state_d  = ole_pkg::StResp;
              end else if (CW'(len_q) == CW'(Depth)) begin
                status_d = ole_pkg::StatusFull;
                state_d  = ole_pkg::StResp;
              end else begin
                pos_d   = LW'(in_pos);
                idx_d   = len_q;
                state_d = ole_pkg::StInsStep;
              end
            end
            ole_pkg::OpRemove: begin
              idx_d   = '0;
              state_d = ole_pkg::StRemRead;
            end
            ole_pkg::OpDump: begin
              if (len_q == '0) begin
                status_d = ole_pkg::StatusEmpty;
                state_d  = ole_pkg::StResp;
              end else begin
                idx_d   = '0;
                state_d = ole_pkg::StDumpRead;
              end
            end
            default: begin
              state_d = ole_pkg::StIdle;
            end
          endcase
        end
      end
      ole_pkg::StInsStep: begin
        if (idx_q == pos_q) begin
          len_d    = len_q + LW'(1);
          status_d = ole_pkg::StatusOk;
          state_d  = ole_pkg::StResp;
        end else begin
          state_d = ole_pkg::StInsMove;
        end
      end
      ole_pkg::StInsMove: begin
        idx_d   = idx_m1;
        state_d = ole_pkg::StInsStep;
      end
      ole_pkg::StRemRead: begin
        if (idx_q == len_q) begin
          status_d = ole_pkg::StatusNotFound;
          state_d  = ole_pkg::StResp;
        end else begin
          state_d = ole_pkg::StRemCmp;
        end
      end
      ole_pkg::StRemCmp: begin
        if (rdata_q == val_q) begin
          state_d = ole_pkg::StRemShift;
        end else begin
          idx_d   = idx_p1;
          state_d = ole_pkg::StRemRead;
        end
      end
      ole_pkg::StRemShift: begin
        if (idx_p1 == len_q) begin
          len_d    = len_q - LW'(1);
          status_d = ole_pkg::StatusOk;
          state_d  = ole_pkg::StResp;
        end else begin
          state_d = ole_pkg::StRemMove;
        end
      end
      ole_pkg::StRemMove: begin
        idx_d   = idx_p1;
        state_d = ole_pkg::StRemShift;
      end
      ole_pkg::StDumpRead: begin
        state_d = ole_pkg::StDumpOut;
      end
      ole_pkg::StDumpOut: begin
        if (res_ready) begin
          if (idx_p1 == len_q) begin
            state_d = ole_pkg::StIdle;
          end else begin
            idx_d   = idx_p1;
            state_d = ole_pkg::StDumpRead;
          end
        end
      end
      ole_pkg::StResp: begin
        if (res_ready) begin
          state_d = ole_pkg::StIdle;
        end
      end
      default: begin
        state_d = ole_pkg::StIdle;
      end
    endcase
  end

  // RAM access and result push
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = idx_q[AW-1:0];
    we         = 1'b0;
    wr_addr    = idx_q[AW-1:0];
    wr_data    = rdata_q;
    res_valid  = 1'b0;
    res.status = status_q;
    res.entry  = '0;
    res.last   = 1'b1;
    case (state_q)
      ole_pkg::StInsStep: begin
        if (idx_q == pos_q) begin
          we      = 1'b1;
          wr_addr = pos_q[AW-1:0];
          wr_data = val_q;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_m1[AW-1:0];
        end
      end
      ole_pkg::StInsMove: begin
        we = 1'b1;
      end
      ole_pkg::StRemRead: begin
        rd_en = (idx_q != len_q);
      end
      ole_pkg::StRemShift: begin
        rd_en   = (idx_p1 != len_q);
        rd_addr = idx_p1[AW-1:0];
      end
      ole_pkg::StRemMove: begin
        we = 1'b1;
      end
      ole_pkg::StDumpRead: begin
        rd_en = 1'b1;
      end
      ole_pkg::StDumpOut: begin
        res_valid  = 1'b1;
        res.status = ole_pkg::StatusEntry;
        res.entry  = rdata_q;
        res.last   = (idx_p1 == len_q);
      end
      ole_pkg::StResp: begin
        res_valid = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ole_pkg::StIdle;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  ole_res_fifo u_res_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_valid_i  (res_valid),
    .push_ready_o  (res_ready),
    .push_data_i   (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(len_q) <= CW'(Depth))
    else $error("list length above depth");

  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(len_q) |-> (len_q == $past(len_q) + LW'(1)) || (len_q == $past(len_q) - LW'(1)))
    else $error("list length moved by more than one");

  a_len_only_on_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(len_q) |-> state_q == ole_pkg::StResp)
    else $error("length changed without a status result");

  a_wr_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> CW'(wr_addr) <= CW'(len_q))
    else $error("RAM write beyond list end");

  a_no_push_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !res_valid && !rd_en && !we)
    else $error("idle engine touching RAM or results");

endmodule

[dv/tb_ordered_list_engine_core.sv]
`timescale 1ns / 100ps

module tb_ordered_list_engine_core;

  localparam int unsigned Depth = ole_pkg::DefaultDepth;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [39:0]                     s_axis_tdata  = '0;   // value[31:0], position[36:32], zero pad
  logic [ole_pkg::OpWidth-1:0]     s_axis_tuser  = '0;   // op
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [ole_pkg::ValueWidth-1:0]  m_axis_tdata;         // entry
  logic [ole_pkg::StatusWidth-1:0] m_axis_tuser;         // status
  logic                            m_axis_tlast;         // last

  ordered_list_engine_core #(
    .Depth(Depth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // shadow copy of the list contents
  logic [ole_pkg::ValueWidth-1:0] shadow_list [Depth];
  int                             shadow_len = 0;
  ole_pkg::res_t                  answer_q [$];
  ole_pkg::res_t                  want;
  int                             fail_cnt   = 0;
  bit                             idle_en    = 1'b1;
  int                             stall_left = 0;

  always #10 clk_i = ~clk_i;

  // apply one accepted op to the shadow list and queue the answers it causes
  task automatic apply_list_op(input ole_pkg::op_e op,
                               input logic [ole_pkg::ValueWidth-1:0] value,
                               input logic [ole_pkg::PosWidth-1:0] pos);
    ole_pkg::res_t r;
    int   i;
    int   hit;
    r.status = ole_pkg::StatusOk;
    r.entry  = '0;
    r.last   = 1'b1;
    hit      = -1;
    case (op)
      ole_pkg::OpInsert: begin
        if (pos > shadow_len) begin
          r.status = ole_pkg::StatusRange;
        end else if (shadow_len >= Depth) begin
          r.status = ole_pkg::StatusFull;
        end else begin
          for (i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = value;
          shadow_len++;
        end
        answer_q.push_back(r);
      end
      ole_pkg::OpRemove: begin
        for (i = 0; i < shadow_len; i++) begin
          if (hit < 0 && shadow_list[i] == value) hit = i;
        end
        if (hit < 0) begin
          r.status = ole_pkg::StatusNotFound;
        end else begin
          for (i = hit; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
        answer_q.push_back(r);
      end
      ole_pkg::OpDump: begin
        if (shadow_len == 0) begin
          r.status = ole_pkg::StatusEmpty;
          answer_q.push_back(r);
        end else begin
          for (i = 0; i < shadow_len; i++) begin
            r.status = ole_pkg::StatusEntry;
            r.entry  = shadow_list[i];
            r.last   = (i + 1 == shadow_len);
            answer_q.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(input ole_pkg::op_e op,
                           input logic [ole_pkg::ValueWidth-1:0] value,
                           input logic [ole_pkg::PosWidth-1:0] pos);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, pos, value};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_list_op(op, value, pos);
  endtask

  // drop valid and let every outstanding answer come back
  task automatic hold_off();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ole_pkg::ValueWidth-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: pick_value = ole_pkg::ValueWidth'($urandom_range(0, 7)) - 32'd4;  // small, gives duplicates
      1: begin
        case ($urandom_range(0, 3))
          0:       pick_value = 32'h8000_0000;
          1:       pick_value = 32'h7fff_ffff;
          2:       pick_value = 32'h0000_0000;
          default: pick_value = 32'hffff_ffff;
        endcase
      end
      default: pick_value = $urandom;
    endcase
  endfunction

  // mostly legal inserts and removes of values present, plus dumps; op 3 items are not counted
  task automatic run_random_items(input int count);
    int done;
    int pick;
    logic [ole_pkg::ValueWidth-1:0] v;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      v    = pick_value();
      if (pick < 45) begin
        send_item(ole_pkg::OpInsert, v, ole_pkg::PosWidth'($urandom_range(0, shadow_len)));
      end else if (pick < 50) begin
        send_item(ole_pkg::OpInsert, v, ole_pkg::PosWidth'($urandom_range(0, 31)));
      end else if (pick < 72 && shadow_len > 0) begin
        send_item(ole_pkg::OpRemove, shadow_list[$urandom_range(0, shadow_len - 1)],
                  ole_pkg::PosWidth'($urandom));
      end else if (pick < 80) begin
        send_item(ole_pkg::OpRemove, v, ole_pkg::PosWidth'($urandom));
      end else if (pick < 96) begin
        send_item(ole_pkg::OpDump, v, ole_pkg::PosWidth'($urandom));
      end else begin
        send_item(ole_pkg::OpNone, v, ole_pkg::PosWidth'($urandom));
        continue;
      end
      done++;
    end
  endtask

  task automatic test_empty_list();
    send_item(ole_pkg::OpDump, 32'h0, 5'd0);
    send_item(ole_pkg::OpRemove, 32'h0, 5'd0);
    send_item(ole_pkg::OpInsert, 32'h1234_5678, 5'd1);
    send_item(ole_pkg::OpNone, 32'hffff_ffff, 5'd31);
  endtask

  task automatic test_fill_and_drain();
    int i;
    send_item(ole_pkg::OpInsert, 32'h7fff_ffff, 5'd0);
    send_item(ole_pkg::OpInsert, 32'h8000_0000, 5'd1);
    send_item(ole_pkg::OpInsert, 32'h0000_0000, 5'd1);
    send_item(ole_pkg::OpInsert, 32'hffff_ffff, 5'd0);
    for (i = 0; i < Depth - 4; i++) begin
      send_item(ole_pkg::OpInsert, ole_pkg::ValueWidth'(i % 6),
                ole_pkg::PosWidth'(i % (shadow_len + 1)));
    end
    // full list: full at the end position, out of range wins past it
    send_item(ole_pkg::OpInsert, 32'h5555_5555, 5'd16);
    send_item(ole_pkg::OpInsert, 32'haaaa_aaaa, 5'd31);
    send_item(ole_pkg::OpDump, 32'h0, 5'd0);
    send_item(ole_pkg::OpRemove, 32'h0000_0000, 5'd0);
    send_item(ole_pkg::OpRemove, 32'h7fff_ffff, 5'd31);
    send_item(ole_pkg::OpRemove, 32'h0bad_cafe, 5'd0);
    send_item(ole_pkg::OpDump, 32'h0, 5'd0);
  endtask

  task automatic test_random_traffic();
    run_random_items(60);
  endtask

  task automatic test_paused_sender();
    int k;
    for (k = 0; k < 3; k++) begin
      hold_off();
      run_random_items(30);
    end
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    run_random_items(40);
  endtask

  // result sink back-pressure
  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (answer_q.size() == 0) begin
        if (fail_cnt < 10) begin
          $display("unexpected result: status %0d entry %h last %b",
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
        fail_cnt++;
      end else begin
        want = answer_q.pop_front();
        if (m_axis_tuser !== want.status || m_axis_tdata !== want.entry ||
            m_axis_tlast !== want.last) begin
          if (fail_cnt < 10) begin
            $display("mismatch: exp status %0d entry %h last %b, got status %0d entry %h last %b",
                     want.status, want.entry, want.last,
                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
          end
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_fill_and_drain();
    test_random_traffic();
    test_paused_sender();
    test_back_to_back();
    hold_off();
    // longest remove scans and shifts the whole list
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0 && answer_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[ordered_list_engine_core.f]
hw/rtl/ole_pkg.sv
hw/rtl/ole_res_fifo.sv
hw/rtl/ordered_list_engine_core.sv
dv/tb_ordered_list_engine_core.sv
